// ===== design/lgs_pkg.sv =====
// Shared types and constants for the life grid generation step unit.
package lgs_pkg;

  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned SUM_W     = COUNT_W + 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_NBRS   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_NBRS = 4'd2;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic wr;     // write one cell (qualified by row/column hits)
    logic wdata;
    logic step;   // advance this row one generation, latch born/died masks
    logic scan;   // shift masks one bit, count ones
    logic drain;  // shift row counts one cell toward row 0
  } cell_ctrl_t;

endpackage

// ===== design/lgs_row_cell.sv =====
// One grid row: its cells, next-generation logic and its born/died counters.
module lgs_row_cell
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_SIDE = 32,
  localparam int unsigned ROW_CNT_W = $clog2(GRID_SIDE + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 frozen_i,
  input  logic                 row_hit_i,
  input  logic [GRID_SIDE-1:0] col_hit_i,
  input  logic [GRID_SIDE-1:0] above_i,
  input  logic [GRID_SIDE-1:0] below_i,
  input  logic [ROW_CNT_W-1:0] born_cnt_i,
  input  logic [ROW_CNT_W-1:0] died_cnt_i,
  output logic [GRID_SIDE-1:0] cells_o,
  output logic                 rd_bit_o,
  output logic [ROW_CNT_W-1:0] born_cnt_o,
  output logic [ROW_CNT_W-1:0] died_cnt_o
);

  logic [GRID_SIDE-1:0] row_q;
  logic [GRID_SIDE-1:0] nxt_row;
  logic [GRID_SIDE-1:0] wr_row;
  logic [GRID_SIDE-1:0] born_q, died_q;
  logic [ROW_CNT_W-1:0] born_cnt_q, died_cnt_q;

  for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
    if (c == 0 || c == GRID_SIDE - 1) begin : g_edge
      assign nxt_row[c] = row_q[c];
    end else begin : g_inner
      logic [NBR_W-1:0] nbrs;
      logic             life;
      assign nbrs = NBR_W'(above_i[c-1]) + NBR_W'(above_i[c]) + NBR_W'(above_i[c+1])
                  + NBR_W'(row_q[c-1])                       + NBR_W'(row_q[c+1])
                  + NBR_W'(below_i[c-1]) + NBR_W'(below_i[c]) + NBR_W'(below_i[c+1]);
      assign life = (nbrs == BIRTH_NBRS) || (row_q[c] && (nbrs == SURVIVE_NBRS));
      assign nxt_row[c] = frozen_i ? row_q[c] : life;
    end
  end

  assign wr_row   = (row_q & ~col_hit_i) | (col_hit_i & {GRID_SIDE{ctrl_i.wdata}});
  assign rd_bit_o = |(row_q & col_hit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.step) begin
      row_q <= nxt_row;
    end else if (ctrl_i.wr && row_hit_i) begin
      row_q <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      born_q     <= nxt_row & ~row_q;
      died_q     <= row_q & ~nxt_row;
      born_cnt_q <= '0;
      died_cnt_q <= '0;
    end else if (ctrl_i.scan) begin
      born_q     <= born_q >> 1;
      died_q     <= died_q >> 1;
      born_cnt_q <= born_cnt_q + ROW_CNT_W'(born_q[0]);
      died_cnt_q <= died_cnt_q + ROW_CNT_W'(died_q[0]);
    end else if (ctrl_i.drain) begin
      born_cnt_q <= born_cnt_i;
      died_cnt_q <= died_cnt_i;
    end
  end

  assign cells_o    = row_q;
  assign born_cnt_o = born_cnt_q;
  assign died_cnt_o = died_cnt_q;

endmodule

// ===== design/life_grid_generation_step_unit.sv =====
// Top level of the life grid generation step unit (B3/S23 on a square grid).
// A GRID_SIDE x GRID_SIDE grid of one-bit cells, all dead after reset, kept as a chain
// of row cells. Read and write requests return their beat in the output register on the
// next cycle. A generation request updates every interior cell in its accept cycle;
// the births and deaths are then counted by shifting each row's masks out one bit a
// cycle and then shifting the per-row counts down the chain into one accumulator,
// after which the result beat appears. Counts saturate at 1023. One request is in
// flight at a time; a new request is taken once the unit is idle and the output
// register is empty or being emptied.
module life_grid_generation_step_unit
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_SIDE = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [4:0]         cell_row_i,
  input  logic [4:0]         cell_col_i,
  input  logic               alive_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               alive_out_o,
  output logic [COUNT_W-1:0] birth_count_o,
  output logic [COUNT_W-1:0] death_count_o
);

  localparam int unsigned ROW_CNT_W = $clog2(GRID_SIDE + 1);
  localparam int unsigned PHASE_W   = $clog2(GRID_SIDE);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(GRID_SIDE - 1);

  state_e state_q, state_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [COUNT_W-1:0] bacc_q, bacc_d, dacc_q, dacc_d;
  logic               out_valid_q, out_valid_d;
  logic               alive_q, alive_d;
  logic [COUNT_W-1:0] birth_q, birth_d, death_q, death_d;

  cell_ctrl_t ctrl;
  logic       in_accept;
  logic       rd_alive;

  logic [GRID_SIDE-1:0] row_hit, col_hit, rd_bits;
  logic [GRID_SIDE-1:0] cells [GRID_SIDE];
  logic [ROW_CNT_W-1:0] born_cnt [GRID_SIDE];
  logic [ROW_CNT_W-1:0] died_cnt [GRID_SIDE];

  logic [SUM_W-1:0] bsum, dsum;
  logic [COUNT_W-1:0] bsat, dsat;

  // -------- address decode, one-hot; out-of-grid addresses hit nothing --------
  for (genvar i = 0; i < GRID_SIDE; i++) begin : g_hit
    assign row_hit[i] = (32'(cell_row_i) == i);
    assign col_hit[i] = (32'(cell_col_i) == i);
  end

  // -------- chain of row cells --------
  for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
    logic [GRID_SIDE-1:0] above, below;
    logic [ROW_CNT_W-1:0] bcnt_in, dcnt_in;

    if (r == 0) begin : g_top
      assign above = '0;
    end else begin : g_up
      assign above = cells[r-1];
    end

    if (r == GRID_SIDE - 1) begin : g_bot
      assign below   = '0;
      assign bcnt_in = '0;
      assign dcnt_in = '0;
    end else begin : g_dn
      assign below   = cells[r+1];
      assign bcnt_in = born_cnt[r+1];
      assign dcnt_in = died_cnt[r+1];
    end

    lgs_row_cell #(
      .GRID_SIDE (GRID_SIDE)
    ) u_row (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .frozen_i   ((r == 0) || (r == GRID_SIDE - 1)),
      .row_hit_i  (row_hit[r]),
      .col_hit_i  (col_hit),
      .above_i    (above),
      .below_i    (below),
      .born_cnt_i (bcnt_in),
      .died_cnt_i (dcnt_in),
      .cells_o    (cells[r]),
      .rd_bit_o   (rd_bits[r]),
      .born_cnt_o (born_cnt[r]),
      .died_cnt_o (died_cnt[r])
    );
  end

  assign rd_alive = |(rd_bits & row_hit);

  // -------- handshake --------
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // -------- saturating accumulate of the count leaving row 0 --------
  assign bsum = SUM_W'(bacc_q) + SUM_W'(born_cnt[0]);
  assign dsum = SUM_W'(dacc_q) + SUM_W'(died_cnt[0]);
  assign bsat = (bsum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : bsum[COUNT_W-1:0];
  assign dsat = (dsum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : dsum[COUNT_W-1:0];

  // -------- next state --------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (req_type_i == REQ_STEP)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (phase_q == PHASE_LAST) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (phase_q == PHASE_LAST) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // -------- outputs and datapath control --------
  always_comb begin
    ctrl        = '0;
    ctrl.wdata  = alive_in_i;
    phase_d     = phase_q;
    bacc_d      = bacc_q;
    dacc_d      = dacc_q;
    out_valid_d = out_valid_q && out_stall_i;
    alive_d     = alive_q;
    birth_d     = birth_q;
    death_d     = death_q;

    unique case (state_q)
      ST_IDLE: begin
        phase_d = '0;
        bacc_d  = '0;
        dacc_d  = '0;
        if (in_accept) begin
          alive_d = 1'b0;
          birth_d = '0;
          death_d = '0;
          unique case (req_type_i)
            REQ_WRITE: begin
              ctrl.wr     = 1'b1;
              out_valid_d = 1'b1;
            end
            REQ_READ: begin
              alive_d     = rd_alive;
              out_valid_d = 1'b1;
            end
            REQ_STEP: begin
              ctrl.step = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        phase_d   = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
      end
      ST_DRAIN: begin
        ctrl.drain = 1'b1;
        bacc_d     = bsat;
        dacc_d     = dsat;
        phase_d    = phase_q + 1'b1;
        if (phase_q == PHASE_LAST) begin
          out_valid_d = 1'b1;
          alive_d     = 1'b0;
          birth_d     = bsat;
          death_d     = dsat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bacc_q  <= bacc_d;
    dacc_q  <= dacc_d;
    alive_q <= alive_d;
    birth_q <= birth_d;
    death_q <= death_d;
  end

  assign out_valid_o   = out_valid_q;
  assign alive_out_o   = alive_q;
  assign birth_count_o = birth_q;
  assign death_count_o = death_q;

`ifndef SYNTHESIS
  // A generation in flight always finds the output register empty.
  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("output beat pending while a generation is counting");

  // A result beat appears only from an accepted request or the end of a drain.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q == ST_DRAIN) || $past(in_accept)))
    else $error("result beat without a source");

  // Border rows never change across a generation.
  a_border_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |=> ((cells[0] == $past(cells[0]))
                && (cells[GRID_SIDE-1] == $past(cells[GRID_SIDE-1]))))
    else $error("border row changed during a generation");
`endif

endmodule

// ===== sim/life_grid_generation_step_unit_tb.sv =====
// Self-checking testbench for the life grid generation step unit.
module life_grid_generation_step_unit_tb;
  import lgs_pkg::*;

  localparam int unsigned GRID_SIDE    = 32;
  localparam int unsigned TOTAL_ITEMS  = 1450;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 4 * GRID_SIDE;
  localparam int unsigned MAX_WAIT     = 11;
  // request code with no operation behind it
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic               alive;
    logic [COUNT_W-1:0] births;
    logic [COUNT_W-1:0] deaths;
  } grid_result_t;

  class life_scoreboard #(int unsigned SIDE = 32);
    bit           cells [SIDE][SIDE];
    grid_result_t expected_q[$];
    int unsigned  error_count;

    function new();
      error_count = 0;
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      error_count++;
    endtask

    // one B3/S23 generation over the interior, border left alone
    function void advance_generation(output logic [COUNT_W-1:0] births,
                                     output logic [COUNT_W-1:0] deaths);
      bit          upd [SIDE][SIDE];
      int unsigned born;
      int unsigned died;
      int unsigned nbrs;
      upd  = cells;
      born = 0;
      died = 0;
      for (int r = 1; r < SIDE - 1; r++) begin
        for (int c = 1; c < SIDE - 1; c++) begin
          nbrs = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) nbrs += cells[r + dr][c + dc];
            end
          end
          if (cells[r][c]) begin
            if (nbrs != SURVIVE_NBRS && nbrs != BIRTH_NBRS) begin
              upd[r][c] = 1'b0;
              died++;
            end
          end else if (nbrs == BIRTH_NBRS) begin
            upd[r][c] = 1'b1;
            born++;
          end
        end
      end
      cells  = upd;
      births = (born > COUNT_MAX) ? COUNT_MAX : COUNT_W'(born);
      deaths = (died > COUNT_MAX) ? COUNT_MAX : COUNT_W'(died);
    endfunction

    function void note_request(logic [1:0] req, logic [4:0] row, logic [4:0] col,
                               logic alive);
      grid_result_t res;
      res = '0;
      case (req)
        REQ_WRITE: begin
          if (row < SIDE && col < SIDE) cells[row][col] = alive;
        end
        REQ_READ: begin
          if (row < SIDE && col < SIDE) res.alive = cells[row][col];
        end
        REQ_STEP: begin
          advance_generation(res.births, res.deaths);
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), res);
    endfunction

    task check_result(logic alive, logic [COUNT_W-1:0] births,
                      logic [COUNT_W-1:0] deaths);
      grid_result_t want;
      if (expected_q.size() == 0) begin
        report("result beat with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (alive !== want.alive)
        report($sformatf("alive_out %b, want %b", alive, want.alive));
      if (births !== want.births)
        report($sformatf("birth_count %0d, want %0d", births, want.births));
      if (deaths !== want.deaths)
        report($sformatf("death_count %0d, want %0d", deaths, want.deaths));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d result beats never arrived", expected_q.size()));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic [4:0]         cell_row_i;
  logic [4:0]         cell_col_i;
  logic               alive_in_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               alive_out_o;
  logic [COUNT_W-1:0] birth_count_o;
  logic [COUNT_W-1:0] death_count_o;

  life_scoreboard #(GRID_SIDE) sb;

  int unsigned item_count;
  int unsigned tx_calm;
  int unsigned rx_calm;
  int unsigned stall_left;
  int unsigned taken_count;
  int unsigned taken_seen;
  int unsigned cycle_count;

  life_grid_generation_step_unit #(
    .GRID_SIDE(GRID_SIDE)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .cell_row_i    (cell_row_i),
    .cell_col_i    (cell_col_i),
    .alive_in_i    (alive_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .alive_out_o   (alive_out_o),
    .birth_count_o (birth_count_o),
    .death_count_o (death_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // wait per beat, with occasional stretches of back-to-back traffic
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [4:0] row,
                              input logic [4:0] col, input logic alive);
    int unsigned gap;
    gap = pick_wait(tx_calm);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    cell_row_i <= row;
    cell_col_i <= col;
    alive_in_i <= alive;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, row, col, alive);
    item_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(alive_out_o, birth_count_o, death_count_o);
      taken_count++;
    end
  end

  // receiver holds off each result beat for a drawn number of cycles
  always @(negedge clk_i) begin
    if (taken_count != taken_seen) begin
      taken_seen = taken_count;
      stall_left = pick_wait(rx_calm);
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0 && out_valid_o) stall_left--;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[life_grid_generation_step_unit] ERROR");
    $finish;
  end

  initial begin
    int unsigned span;
    int unsigned base_r;
    int unsigned base_c;
    int unsigned density;
    int unsigned mode;
    sb          = new();
    item_count  = 0;
    tx_calm     = 0;
    rx_calm     = 0;
    stall_left  = $urandom_range(0, MAX_WAIT);
    taken_count = 0;
    taken_seen  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_WRITE;
    cell_row_i  = '0;
    cell_col_i  = '0;
    alive_in_i  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // grid starts empty; corners of the border
    send_request(REQ_READ, 5'd0, 5'd0, 1'b1);
    send_request(REQ_WRITE, 5'd0, 5'd0, 1'b1);
    send_request(REQ_WRITE, 5'd31, 5'd31, 1'b1);
    send_request(REQ_WRITE, 5'd0, 5'd31, 1'b1);
    send_request(REQ_WRITE, 5'd31, 5'd0, 1'b1);
    // blinker: two births, two deaths, border untouched
    send_request(REQ_WRITE, 5'd10, 5'd9, 1'b1);
    send_request(REQ_WRITE, 5'd10, 5'd10, 1'b1);
    send_request(REQ_WRITE, 5'd10, 5'd11, 1'b1);
    send_request(REQ_STEP, 5'd0, 5'd0, 1'b0);
    send_request(REQ_READ, 5'd0, 5'd0, 1'b0);
    send_request(REQ_READ, 5'd9, 5'd10, 1'b0);
    send_request(REQ_READ, 5'd10, 5'd9, 1'b0);
    // spare request code changes nothing and returns zeros
    send_request(REQ_SPARE, 5'd31, 5'd31, 1'b1);
    send_request(REQ_READ, 5'd31, 5'd31, 1'b0);
    send_request(REQ_WRITE, 5'd31, 5'd31, 1'b0);
    send_request(REQ_READ, 5'd31, 5'd31, 1'b1);
    // border row feeding a birth just inside
    send_request(REQ_WRITE, 5'd0, 5'd14, 1'b1);
    send_request(REQ_WRITE, 5'd0, 5'd15, 1'b1);
    send_request(REQ_WRITE, 5'd0, 5'd16, 1'b1);
    send_request(REQ_STEP, 5'd31, 5'd31, 1'b1);
    send_request(REQ_STEP, 5'd15, 5'd16, 1'b0);
    send_request(REQ_READ, 5'd1, 5'd15, 1'b0);
    send_request(REQ_READ, 5'd0, 5'd15, 1'b0);

    while (item_count < TOTAL_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        // seed a patch, let it evolve, peek into it
        span    = $urandom_range(3, 10);
        base_r  = $urandom_range(0, GRID_SIDE - span);
        base_c  = $urandom_range(0, GRID_SIDE - span);
        density = $urandom_range(20, 90);
        repeat ($urandom_range(span, span * span)) begin
          send_request(REQ_WRITE, 5'(base_r + $urandom_range(0, span - 1)),
                       5'(base_c + $urandom_range(0, span - 1)),
                       $urandom_range(1, 100) <= density);
        end
        repeat ($urandom_range(1, 5)) begin
          send_request(REQ_STEP, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 3)) begin
            send_request(REQ_READ, 5'(base_r + $urandom_range(0, span - 1)),
                         5'(base_c + $urandom_range(0, span - 1)),
                         1'($urandom_range(0, 1)));
          end
        end
      end else if (mode <= 7) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(REQ_READ, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_drained();
    if (sb.error_count == 0) begin
      $display("[life_grid_generation_step_unit] OK");
    end else begin
      $display("[life_grid_generation_step_unit] ERROR");
    end
    $finish;
  end

endmodule
